/* hw/rtl/amec_pkg.sv */
// Package for the accelerometer motion event counter.
// Holds register field widths, reset values, register indexes and the configuration struct.
// No dependencies.
`default_nettype none

package amec_pkg;

    localparam int THRESH_W    = 16;
    localparam int GRAV_W      = 15;
    localparam int RECAL_W     = 16;
    localparam int EVCNT_W     = 16;
    localparam int TOTAL_OUT_W = 16;
    localparam int FLAGS_W     = 3;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    localparam logic [THRESH_W-1:0] THRESHOLD_RST = 16'd300;
    localparam logic [GRAV_W-1:0]   GRAVITY_RST   = 15'd1000;
    localparam logic [RECAL_W-1:0]  RECAL_RST     = 16'd100;

    localparam int FLAG_X = 0;
    localparam int FLAG_Y = 1;
    localparam int FLAG_Z = 2;

    typedef enum logic [1:0] {
        REG_THRESHOLD      = 2'd0,
        REG_GRAVITY_OFFSET = 2'd1,
        REG_RECAL_SAMPLES  = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [THRESH_W-1:0] threshold;
        logic [GRAV_W-1:0]   gravity_offset;
        logic [RECAL_W-1:0]  recal_samples;
    } t_cfg;

endpackage

`default_nettype wire

/* hw/rtl/amec_if.sv */
// Handshake interfaces for the accelerometer motion event counter.
// A sample channel carries one three-axis item, a result channel one result item.
// Depends on amec_pkg.
`default_nettype none

interface amec_sample_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] accel_x;
    logic signed [SAMPLE_WIDTH-1:0] accel_y;
    logic signed [SAMPLE_WIDTH-1:0] accel_z;

    modport source (output valid, output accel_x, output accel_y, output accel_z, input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface

interface amec_result_if;
    logic                             valid;
    logic                             ready;
    logic [amec_pkg::FLAGS_W-1:0]     axis_flags;
    logic                             event_active;
    logic                             event_closed;
    logic [amec_pkg::TOTAL_OUT_W-1:0] trigger_total;

    modport source (output valid, output axis_flags, output event_active,
                    output event_closed, output trigger_total, input ready);
    modport sink   (input valid, input axis_flags, input event_active,
                    input event_closed, input trigger_total, output ready);
endinterface

`default_nettype wire

/* hw/rtl/accel_motion_event_counter.sv */
// Accelerometer motion event counter, top level.
// Throughput: one item per cycle while the result channel does not stall; the input register
// and the result register form a two-stage pipeline, and the event state is updated as an item
// moves into the result register.
// Reset (synchronous, active low) clears baselines, event state and counts, and loads the
// register defaults threshold 300, gravity offset 1000 and recal samples 100.
`default_nettype none

module accel_motion_event_counter #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COUNT_WIDTH  = 16
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    amec_sample_if.sink                        i_sample,
    amec_result_if.source                      o_result,
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire  [amec_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire  [amec_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [amec_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import amec_pkg::*;

    // The baseline must hold both raw samples and the folded z magnitude.
    localparam int BASE_W = ((SAMPLE_WIDTH > GRAV_W + 1) ? SAMPLE_WIDTH : GRAV_W + 1) + 1;

    t_cfg w_cfg;

    logic                           r_s1_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_s1_x;
    logic signed [SAMPLE_WIDTH-1:0] r_s1_y;
    logic signed [SAMPLE_WIDTH-1:0] r_s1_z;

    logic signed [BASE_W-1:0] r_base_x;
    logic signed [BASE_W-1:0] r_base_y;
    logic signed [BASE_W-1:0] r_base_z;
    logic                     r_in_event;
    logic [EVCNT_W-1:0]       r_event_samples;
    logic [COUNT_WIDTH-1:0]   r_total;

    logic                     r_out_valid;
    logic [FLAGS_W-1:0]       r_out_flags;
    logic                     r_out_active;
    logic                     r_out_closed;
    logic [TOTAL_OUT_W-1:0]   r_out_total;

    logic signed [BASE_W-1:0] n_base_x;
    logic signed [BASE_W-1:0] n_base_y;
    logic signed [BASE_W-1:0] n_base_z;
    logic                     n_in_event;
    logic [EVCNT_W-1:0]       n_event_samples;
    logic [COUNT_WIDTH-1:0]   n_total;
    logic                     n_closed;

    logic                     w_advance;
    logic                     w_accept;
    logic signed [BASE_W-1:0] w_x;
    logic signed [BASE_W-1:0] w_y;
    logic signed [BASE_W-1:0] w_z_diff;
    logic signed [BASE_W-1:0] w_z;
    logic signed [BASE_W-1:0] w_min_x;
    logic signed [BASE_W-1:0] w_min_y;
    logic signed [BASE_W-1:0] w_min_z;
    logic [FLAGS_W-1:0]       w_flags;

    amec_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_advance      = r_s1_valid && (!r_out_valid || o_result.ready);
    assign i_sample.ready = !r_s1_valid || w_advance;
    assign w_accept       = i_sample.valid && i_sample.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_sample.ready) begin
            r_s1_valid <= i_sample.valid;
        end
        if (w_accept) begin
            r_s1_x <= i_sample.accel_x;
            r_s1_y <= i_sample.accel_y;
            r_s1_z <= i_sample.accel_z;
        end
    end

    assign w_x      = BASE_W'(r_s1_x);
    assign w_y      = BASE_W'(r_s1_y);
    assign w_z_diff = BASE_W'(r_s1_z) - $signed(BASE_W'(w_cfg.gravity_offset));
    assign w_z      = w_z_diff[BASE_W-1] ? -w_z_diff : w_z_diff;

    amec_axis #(.BASE_W(BASE_W)) u_axis_x (
        .i_value     (w_x),
        .i_base      (r_base_x),
        .i_idle      (!r_in_event),
        .i_threshold (w_cfg.threshold),
        .o_base      (w_min_x),
        .o_active    (w_flags[FLAG_X])
    );

    amec_axis #(.BASE_W(BASE_W)) u_axis_y (
        .i_value     (w_y),
        .i_base      (r_base_y),
        .i_idle      (!r_in_event),
        .i_threshold (w_cfg.threshold),
        .o_base      (w_min_y),
        .o_active    (w_flags[FLAG_Y])
    );

    amec_axis #(.BASE_W(BASE_W)) u_axis_z (
        .i_value     (w_z),
        .i_base      (r_base_z),
        .i_idle      (!r_in_event),
        .i_threshold (w_cfg.threshold),
        .o_base      (w_min_z),
        .o_active    (w_flags[FLAG_Z])
    );

    always_comb begin
        n_base_x        = r_base_x;
        n_base_y        = r_base_y;
        n_base_z        = r_base_z;
        n_in_event      = r_in_event;
        n_event_samples = r_event_samples;
        n_total         = r_total;
        n_closed        = 1'b0;
        if (!r_in_event) begin
            n_base_x = w_min_x;
            n_base_y = w_min_y;
            n_base_z = w_min_z;
            if (|w_flags) begin
                n_in_event      = 1'b1;
                n_event_samples = '0;
            end
        end else if (|w_flags) begin
            if (r_event_samples == w_cfg.recal_samples) begin
                n_base_x        = w_x;
                n_base_y        = w_y;
                n_base_z        = w_z;
                n_event_samples = EVCNT_W'(1);
            end else begin
                n_event_samples = r_event_samples + EVCNT_W'(1);
            end
        end else begin
            if (r_total != '1) begin
                n_total = r_total + COUNT_WIDTH'(1);
            end
            n_in_event = 1'b0;
            n_closed   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_x        <= '0;
            r_base_y        <= '0;
            r_base_z        <= '0;
            r_in_event      <= 1'b0;
            r_event_samples <= '0;
            r_total         <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (w_advance) begin
                r_base_x        <= n_base_x;
                r_base_y        <= n_base_y;
                r_base_z        <= n_base_z;
                r_in_event      <= n_in_event;
                r_event_samples <= n_event_samples;
                r_total         <= n_total;
                r_out_valid     <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_advance) begin
            r_out_flags  <= w_flags;
            r_out_active <= n_in_event;
            r_out_closed <= n_closed;
            r_out_total  <= TOTAL_OUT_W'(n_total);
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.axis_flags    = r_out_flags;
    assign o_result.event_active  = r_out_active;
    assign o_result.event_closed  = r_out_closed;
    assign o_result.trigger_total = r_out_total;

`ifndef NO_ASSERTIONS
    a_closed_is_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_closed) |-> (!r_out_active && (r_out_flags == '0)))
        else $error("closing result carries active flags or an open event");

    a_active_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_active == r_in_event))
        else $error("pending result disagrees with event state");

    a_total_steps_by_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_total != $past(r_total)) |-> (r_total == $past(r_total) + COUNT_WIDTH'(1)))
        else $error("event total moved by other than one");

    a_advance_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("item advanced but no result is pending");
`endif

endmodule

`default_nettype wire

/* hw/rtl/amec_cfg.sv */
// APB-style configuration registers: threshold, gravity offset and recal sample count.
// Depends on amec_pkg.
`default_nettype none

module amec_cfg (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire  [amec_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire  [amec_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [amec_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output amec_pkg::t_cfg                     o_cfg
);
    import amec_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_write;

    assign w_idx   = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign w_write = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold      <= THRESHOLD_RST;
            r_cfg.gravity_offset <= GRAVITY_RST;
            r_cfg.recal_samples  <= RECAL_RST;
        end else if (w_write) begin
            case (w_idx)
                REG_THRESHOLD:      r_cfg.threshold      <= pwdata[THRESH_W-1:0];
                REG_GRAVITY_OFFSET: r_cfg.gravity_offset <= pwdata[GRAV_W-1:0];
                REG_RECAL_SAMPLES:  r_cfg.recal_samples  <= pwdata[RECAL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_THRESHOLD:      prdata = APB_DATA_W'(r_cfg.threshold);
            REG_GRAVITY_OFFSET: prdata = APB_DATA_W'(r_cfg.gravity_offset);
            REG_RECAL_SAMPLES:  prdata = APB_DATA_W'(r_cfg.recal_samples);
            default:            prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/amec_axis.sv */
// Per-axis test: running-minimum baseline tracking while idle and excess-over-threshold check.
// Depends on amec_pkg.
`default_nettype none

module amec_axis #(
    parameter int BASE_W = 17
) (
    input  wire signed [BASE_W-1:0]            i_value,
    input  wire signed [BASE_W-1:0]            i_base,
    input  wire                                i_idle,
    input  wire        [amec_pkg::THRESH_W-1:0] i_threshold,
    output logic signed [BASE_W-1:0]           o_base,
    output logic                               o_active
);
    import amec_pkg::*;

    logic signed [BASE_W:0] w_excess;
    logic signed [BASE_W:0] w_thresh;

    // While idle the baseline first follows the minimum, so the excess is never negative.
    assign o_base   = (i_idle && (i_value < i_base)) ? i_value : i_base;
    assign w_excess = (BASE_W+1)'(i_value) - (BASE_W+1)'(o_base);
    assign w_thresh = $signed({{(BASE_W+1-THRESH_W){1'b0}}, i_threshold});
    assign o_active = w_excess > w_thresh;

endmodule

`default_nettype wire

/* verif/accel_motion_event_counter_tb.sv */
// Testbench for the accelerometer motion event counter.
// Sends sample items and APB register writes, predicts every result item and checks it field by field.
// Depends on amec_pkg, the amec_if interfaces and accel_motion_event_counter.
module accel_motion_event_counter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import amec_pkg::*;

    localparam int         SAMPLE_W  = 16;
    localparam int         COUNT_W   = 16;
    localparam logic [1:0] REG_SPARE = 2'd3;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef struct packed {
        logic [FLAGS_W-1:0]     axis_flags;
        logic                   event_active;
        logic                   event_closed;
        logic [TOTAL_OUT_W-1:0] trigger_total;
    } t_motion_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    amec_sample_if #(.SAMPLE_WIDTH(SAMPLE_W)) sample_ch ();
    amec_result_if                            result_ch ();

    accel_motion_event_counter #(
        .SAMPLE_WIDTH(SAMPLE_W),
        .COUNT_WIDTH (COUNT_W)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sample(sample_ch),
        .o_result(result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_cfg                   cfg_model    = '{THRESHOLD_RST, GRAVITY_RST, RECAL_RST};
    logic signed [SAMPLE_W:0] base_x     = '0;
    logic signed [SAMPLE_W:0] base_y     = '0;
    logic signed [SAMPLE_W:0] base_z     = '0;
    logic                   in_motion    = 1'b0;
    logic [RECAL_W-1:0]     motion_len   = '0;
    logic [TOTAL_OUT_W-1:0] motion_count = '0;

    t_motion_result motion_results_due[$];

    int mismatches     = 0;
    int samples_sent   = 0;
    int results_seen   = 0;
    int reg_writes     = 0;
    bit sender_idles   = 1'b1;
    bit receiver_idles = 1'b1;
    int hold_request   = 0;
    bit hold_active    = 1'b0;

    always #2 i_clk = ~i_clk;

    function automatic t_motion_result track_motion(input t_sample ax, input t_sample ay,
                                                    input t_sample az);
        t_motion_result r;
        int x, y, z, th, dx, dy, dz;
        r  = '0;
        x  = ax;
        y  = ay;
        z  = int'(az) - int'(cfg_model.gravity_offset);
        if (z < 0) z = -z;
        th = int'(cfg_model.threshold);
        if (!in_motion) begin
            if (x < base_x) base_x = x[SAMPLE_W:0];
            if (y < base_y) base_y = y[SAMPLE_W:0];
            if (z < base_z) base_z = z[SAMPLE_W:0];
            dx = x - base_x;
            dy = y - base_y;
            dz = z - base_z;
            r.axis_flags[FLAG_X] = (dx > th) || (-dx > th);
            r.axis_flags[FLAG_Y] = (dy > th) || (-dy > th);
            r.axis_flags[FLAG_Z] = (dz > th) || (-dz > th);
            if (r.axis_flags != '0) begin
                in_motion  = 1'b1;
                motion_len = '0;
            end
        end else begin
            dx = x - base_x;
            dy = y - base_y;
            dz = z - base_z;
            r.axis_flags[FLAG_X] = dx > th;
            r.axis_flags[FLAG_Y] = dy > th;
            r.axis_flags[FLAG_Z] = dz > th;
            if (r.axis_flags != '0) begin
                if (motion_len == cfg_model.recal_samples) begin
                    base_x     = x[SAMPLE_W:0];
                    base_y     = y[SAMPLE_W:0];
                    base_z     = z[SAMPLE_W:0];
                    motion_len = '0;
                end
                motion_len = motion_len + 1'b1;
            end else begin
                if (motion_count != '1) motion_count = motion_count + 1'b1;
                in_motion      = 1'b0;
                r.event_closed = 1'b1;
            end
        end
        r.event_active  = in_motion;
        r.trigger_total = motion_count;
        return r;
    endfunction

    function automatic t_sample clip(input int v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return t_sample'(v);
    endfunction

    function automatic int jitter(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    task automatic send_sample(input t_sample ax, input t_sample ay, input t_sample az);
        if (sender_idles && $urandom_range(0, 5) == 0) begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        sample_ch.valid   <= 1'b1;
        sample_ch.accel_x <= ax;
        sample_ch.accel_y <= ay;
        sample_ch.accel_z <= az;
        do @(posedge i_clk); while (!sample_ch.ready);
        motion_results_due.push_back(track_motion(ax, ay, az));
        samples_sent++;
    endtask

    task automatic drain_results();
        sample_ch.valid <= 1'b0;
        while (motion_results_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic write, input logic [1:0] index,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {index, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [APB_DATA_W-1:0] value);
        logic [APB_DATA_W-1:0] unused;
        apb_access(1'b1, index, value, unused);
        reg_writes++;
        case (index)
            REG_THRESHOLD:      cfg_model.threshold      = value[THRESH_W-1:0];
            REG_GRAVITY_OFFSET: cfg_model.gravity_offset = value[GRAV_W-1:0];
            REG_RECAL_SAMPLES:  cfg_model.recal_samples  = value[RECAL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic check_reg(input logic [1:0] index, input logic [APB_DATA_W-1:0] want);
        logic [APB_DATA_W-1:0] got;
        apb_access(1'b0, index, '0, got);
        if (got !== want) begin
            $error("prdata of register %0d: expected %0h, got %0h", index, want, got);
            mismatches++;
        end
    endtask

    task automatic check_all_regs();
        check_reg(REG_THRESHOLD,      32'(cfg_model.threshold));
        check_reg(REG_GRAVITY_OFFSET, 32'(cfg_model.gravity_offset));
        check_reg(REG_RECAL_SAMPLES,  32'(cfg_model.recal_samples));
    endtask

    task automatic set_config(input logic [THRESH_W-1:0] th, input logic [GRAV_W-1:0] grav,
                              input logic [RECAL_W-1:0] recal);
        logic [31:0] junk;
        junk = $urandom();
        drain_results();
        write_reg(REG_THRESHOLD,      {junk[31:16], th});
        write_reg(REG_GRAVITY_OFFSET, {junk[31:15], grav});
        write_reg(REG_RECAL_SAMPLES,  {junk[31:16], recal});
        check_all_regs();
    endtask

    task automatic test_register_access();
        check_all_regs();
        write_reg(REG_SPARE, '1);
        check_all_regs();
    endtask

    task automatic test_directed_events();
        set_config(16'd300, 15'd1000, 16'd2);
        send_sample(0, 0, 1000);
        send_sample(-32768, 32767, -32768);
        send_sample(32767, 32767, 32767);
        send_sample(0, -32768, 1000);
        send_sample(100, 0, 0);
        send_sample(50, -500, 2000);
        send_sample(50, -500, 2000);
        send_sample(-400, -500, 1000);
        send_sample(-99, -500, 1000);
        send_sample(-100, -500, 1000);
        send_sample(-100, -500, 1000);
        send_sample(-400, -500, 699);
        send_sample(-400, -500, 1301);
        send_sample(-400, -500, 1000);
        // With a recalibration count of zero the first sample after an event opens re-seeds the baselines.
        set_config(16'd300, 15'd1000, 16'd0);
        send_sample(32767, 0, 1000);
        send_sample(32767, 0, 1000);
        send_sample(32767, 0, 1000);
        send_sample(-32768, -32768, 1000);
        drain_results();
    endtask

    task automatic run_random_phase(input logic [THRESH_W-1:0] th, input logic [GRAV_W-1:0] grav,
                                    input logic [RECAL_W-1:0] recal, input int count,
                                    input bit with_idles);
        int  sent, span, run, longest, lift;
        int  rest_x, rest_y, rest_z;
        bit [2:0] axes;
        set_config(th, grav, recal);
        sender_idles   = with_idles;
        receiver_idles = with_idles;
        span    = int'(th) / 2;
        longest = (recal < 20) ? 2 * int'(recal) + 3 : 12;
        rest_x  = int'($urandom_range(0, 65535)) - 32768;
        rest_y  = int'($urandom_range(0, 65535)) - 32768;
        rest_z  = int'(grav) + jitter(200);
        sent    = 0;
        while (sent < count) begin
            case ($urandom_range(0, 9))
                0: begin
                    send_sample(t_sample'($urandom()), t_sample'($urandom()),
                                t_sample'($urandom()));
                    sent++;
                    if ($urandom_range(0, 3) == 0) begin
                        rest_x = int'($urandom_range(0, 65535)) - 32768;
                        rest_y = int'($urandom_range(0, 65535)) - 32768;
                    end
                end
                1, 2, 3, 4: begin
                    run = int'($urandom_range(1, 6));
                    repeat (run) begin
                        send_sample(clip(rest_x + jitter(span)), clip(rest_y + jitter(span)),
                                    clip(rest_z + jitter(span)));
                        sent++;
                    end
                end
                default: begin
                    run = int'($urandom_range(1, longest));
                    repeat (run) begin
                        axes = 3'($urandom_range(1, 7));
                        lift = int'(th) + 1 + int'($urandom_range(0, 300));
                        send_sample(axes[0] ? clip(rest_x + lift) : clip(rest_x + jitter(span)),
                                    axes[1] ? clip(rest_y + lift) : clip(rest_y + jitter(span)),
                                    axes[2] ? clip(rest_z + lift) : clip(rest_z + jitter(span)));
                        sent++;
                    end
                end
            endcase
        end
        drain_results();
    endtask

    task automatic test_random_traffic();
        run_random_phase(16'd300, 15'd1000, 16'd100, 200, 1'b1);
        run_random_phase(16'd0, 15'd0, 16'd1, 200, 1'b1);
        run_random_phase(16'd65535, 15'd32767, 16'd65535, 200, 1'b1);
        run_random_phase(16'd64, 15'd16384, 16'd3, 200, 1'b1);
        run_random_phase(16'd1000, 15'd500, 16'd0, 200, 1'b1);
        run_random_phase(16'($urandom_range(0, 2000)), 15'($urandom_range(0, 32767)),
                         16'($urandom_range(1, 8)), 200, 1'b0);
        run_random_phase(16'd200, 15'd32767, 16'd2, 200, 1'b1);
    endtask

    task automatic test_output_backpressure();
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        hold_request   = 80;
        wait (hold_active);
        repeat (30) begin
            send_sample(t_sample'($urandom()), t_sample'($urandom()), t_sample'($urandom()));
        end
        drain_results();
    endtask

    task automatic test_event_counting();
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        set_config(16'd100, 15'd0, 16'd100);
        send_sample(-32768, -32768, 0);
        send_sample(-32768, -32768, 0);
        repeat (12) begin
            send_sample(32767, -32768, 0);
            send_sample(-32768, -32768, 0);
        end
        drain_results();
    endtask

    initial begin : result_sink
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                result_ch.ready <= 1'b0;
                hold_active = 1'b1;
                repeat (hold_request) @(posedge i_clk);
                hold_request = 0;
                hold_active  = 1'b0;
            end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end
            result_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_motion_result due;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            results_seen++;
            if (motion_results_due.size() == 0) begin
                $error("result item arrived with no sample waiting for it");
                mismatches++;
            end else begin
                due = motion_results_due.pop_front();
                if (result_ch.axis_flags !== due.axis_flags) begin
                    $error("axis_flags: expected %0h, got %0h", due.axis_flags,
                           result_ch.axis_flags);
                    mismatches++;
                end
                if (result_ch.event_active !== due.event_active) begin
                    $error("event_active: expected %0h, got %0h", due.event_active,
                           result_ch.event_active);
                    mismatches++;
                end
                if (result_ch.event_closed !== due.event_closed) begin
                    $error("event_closed: expected %0h, got %0h", due.event_closed,
                           result_ch.event_closed);
                    mismatches++;
                end
                if (result_ch.trigger_total !== due.trigger_total) begin
                    $error("trigger_total: expected %0d, got %0d", due.trigger_total,
                           result_ch.trigger_total);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #5ms;
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        i_rst_n           <= 1'b0;
        sample_ch.valid   <= 1'b0;
        sample_ch.accel_x <= '0;
        sample_ch.accel_y <= '0;
        sample_ch.accel_z <= '0;
        result_ch.ready   <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_register_access();
        test_directed_events();
        test_random_traffic();
        test_output_backpressure();
        test_event_counting();

        drain_results();
        repeat (8) @(posedge i_clk);
        $display("Checked %0d result items against %0d samples, with %0d register writes.",
                 results_seen, samples_sent, reg_writes);
        $display("Settings ranged over both threshold and offset extremes; event count ended at %0d.",
                 motion_count);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* accel_motion_event_counter.f */
hw/rtl/amec_pkg.sv
hw/rtl/amec_if.sv
hw/rtl/amec_cfg.sv
hw/rtl/amec_axis.sv
hw/rtl/accel_motion_event_counter.sv
verif/accel_motion_event_counter_tb.sv
